/* rtl/smlau_pkg.sv */
`default_nettype none

package smlau_pkg;

  localparam int unsigned ACTION_W  = 3;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned IMM_W     = 16;
  localparam int unsigned OFF2_W    = 8;
  localparam int unsigned SIZE_W    = 17;
  localparam int unsigned PADDR_W   = 3;
  localparam int unsigned PDATA_W   = 32;

  // Register map: byte address bit 2 selects the register word.
  localparam logic REG_SHARED_BYTES = 1'b0;
  localparam logic [SIZE_W-1:0] SHARED_BYTES_RST = 17'h10000;

  // Remainder unit: bits of dividend retired per cycle.
  localparam int unsigned MOD_BITS_PER_CYC = 4;
  localparam int unsigned MOD_CYCLES       = WORD_W / MOD_BITS_PER_CYC;
  localparam int unsigned MOD_CNT_W        = $clog2(MOD_CYCLES);

  typedef enum logic [ACTION_W-1:0] {
    ACT_WRITE = 3'd0,
    ACT_READ  = 3'd1,
    ACT_PAIR  = 3'd2,
    ACT_ADD   = 3'd3,
    ACT_MIN   = 3'd4,
    ACT_MAX   = 3'd5,
    ACT_SWAP  = 3'd6
  } action_e;

  // True when a whole word starting at byte address a lies below size.
  function automatic logic word_fits(input logic [WORD_W-1:0] a,
                                     input logic [SIZE_W-1:0] size);
    logic [WORD_W:0] a_end;
    logic [WORD_W:0] size_ext;
    a_end    = {1'b0, a} + (WORD_W+1)'(4);
    size_ext = (WORD_W+1)'(size);
    return a_end <= size_ext;
  endfunction

  function automatic logic is_single_word(input logic [ACTION_W-1:0] act);
    logic res;
    case (act)
      ACT_WRITE, ACT_READ, ACT_ADD, ACT_MIN, ACT_MAX, ACT_SWAP: res = 1'b1;
      default: res = 1'b0;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

/* rtl/smlau_if.sv */
`default_nettype none

interface smlau_in_if import smlau_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [WORD_W-1:0]   lane_address;
  logic [IMM_W-1:0]    imm_offset;
  logic [OFF2_W-1:0]   second_offset;
  logic [WORD_W-1:0]   write_data;

  modport source (output valid, action, lane_address, imm_offset, second_offset,
                  write_data, input ready);
  modport sink (input valid, action, lane_address, imm_offset, second_offset,
                write_data, output ready);
endinterface

interface smlau_out_if import smlau_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              performed;
  logic [WORD_W-1:0] first_value;
  logic [WORD_W-1:0] second_value;

  modport source (output valid, performed, first_value, second_value, input ready);
  modport sink (input valid, performed, first_value, second_value, output ready);
endinterface

`default_nettype wire

/* rtl/smlau_mod.sv */
`default_nettype none

module smlau_mod import smlau_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [WORD_W-1:0] dividend_i,
  input  wire logic [SIZE_W-1:0] divisor_i,
  output logic                   done_o,
  output logic [SIZE_W-1:0]      rem_o
);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [MOD_CNT_W-1:0] cnt_q, cnt_d;
  logic [WORD_W-1:0]    dvd_q, dvd_d;
  logic [SIZE_W-1:0]    rem_q, rem_d;
  logic [SIZE_W-1:0]    div_q, div_d;
  logic [SIZE_W-1:0]    rem_step;

  // Restoring remainder, several dividend bits per cycle. The partial
  // remainder stays below the divisor, so one extra bit is enough.
  always_comb begin
    logic [SIZE_W:0] trial;
    logic [SIZE_W-1:0] r;
    r = rem_q;
    for (int k = 0; k < MOD_BITS_PER_CYC; k++) begin
      trial = {r, dvd_q[WORD_W-1-k]};
      if (trial >= {1'b0, div_q}) begin
        trial = trial - {1'b0, div_q};
      end
      r = trial[SIZE_W-1:0];
    end
    rem_step = r;
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    div_d  = div_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = dividend_i;
      rem_d  = '0;
      div_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = rem_step;
      dvd_d = dvd_q << MOD_BITS_PER_CYC;
      cnt_d = cnt_q + MOD_CNT_W'(1);
      if (cnt_q == MOD_CNT_W'(MOD_CYCLES - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

/* rtl/smlau_mem.sv */
`default_nettype none

module smlau_mem import smlau_pkg::*; #(
  parameter  int unsigned STORE_BYTES = 65536,
  localparam int unsigned BANK_DEPTH  = (STORE_BYTES + 3) / 4,
  localparam int unsigned ROW_W       = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1,
  localparam int unsigned ADDR_W      = ROW_W + 2
) (
  input  wire logic              clk_i,
  input  wire logic              rd_en_i,
  input  wire logic              wr_en_i,
  input  wire logic [ADDR_W-1:0] addr_i,
  input  wire logic [WORD_W-1:0] wdata_i,
  output logic [WORD_W-1:0]      rdata_o
);

  // Four byte banks interleaved on the low address bits, so any word,
  // aligned or not, touches each bank exactly once.
  logic [1:0]       lo;
  logic [ROW_W-1:0] row_base;
  logic [1:0]       lo_q;
  logic [3:0][7:0]  bank_rd;

  assign lo       = addr_i[1:0];
  assign row_base = addr_i[ADDR_W-1:2];

  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [7:0]       mem_q [BANK_DEPTH];
    logic [7:0]       rd_q;
    logic [1:0]       byte_sel;
    logic [ROW_W-1:0] row;
    logic [7:0]       wbyte;

    assign byte_sel = 2'(b) - lo;
    assign row      = row_base + ((2'(b) < lo) ? ROW_W'(1) : ROW_W'(0));
    assign wbyte    = wdata_i[8*byte_sel +: 8];

    always_ff @(posedge clk_i) begin
      if (wr_en_i) begin
        mem_q[row] <= wbyte;
      end
      if (rd_en_i) begin
        rd_q <= mem_q[row];
      end
    end

    assign bank_rd[b] = rd_q;
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      lo_q <= lo;
    end
  end

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      rdata_o[8*j +: 8] = bank_rd[2'(lo_q + 2'(j))];
    end
  end

endmodule

`default_nettype wire

/* rtl/shared_memory_lane_access_unit_core.sv */
// Shared memory lane access unit.
//
// One lane access enters on in_i and one result leaves on out_o; both
// channels transfer on a clock edge with valid and ready high. The store
// is held as four interleaved byte banks, so an unaligned word is read or
// written with one access to each bank.
// Single-word actions first reduce the address modulo the shared size in
// an iterative remainder unit that retires four bits a cycle; the access
// then runs in S_EXEC if the word fits, and its result passes through
// S_DONE into the output register.
// A paired read needs no modulo; it reads both words in S_P0 to S_P2
// before S_DONE.
// in_i is ready only while no access is in progress; the next item is
// taken as soon as the result has moved to the output register, so a
// stalled receiver holds back at most one further item.
// Reset clears the sequencer and the output valid and sets shared_bytes
// to 65536; the store contents are undefined until written.
// shared_bytes sits at APB byte address 0; writes complete in the access
// cycle, pready is always high.

`default_nettype none

module shared_memory_lane_access_unit_core import smlau_pkg::*; #(
  parameter int unsigned STORE_BYTES = 65536
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  smlau_in_if.sink                in_i,
  smlau_out_if.source             out_o,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0]      prdata,
  output logic                    pready
);

  localparam int unsigned BANK_DEPTH = (STORE_BYTES + 3) / 4;
  localparam int unsigned ROW_W      = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
  localparam int unsigned ADDR_W     = ROW_W + 2;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MOD  = 3'd1;
  localparam logic [2:0] S_EXEC = 3'd2;
  localparam logic [2:0] S_P0   = 3'd3;
  localparam logic [2:0] S_P1   = 3'd4;
  localparam logic [2:0] S_P2   = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0]          state_q, state_d;
  logic [SIZE_W-1:0]   shared_bytes_q;
  logic                out_valid_q;

  logic [ACTION_W-1:0] act_q;
  logic [WORD_W-1:0]   data_q;
  logic [SIZE_W-1:0]   size_q;
  logic [WORD_W-1:0]   addr_a_q, addr_b_q;
  logic [SIZE_W-1:0]   addr_q, addr_d;

  logic                res_perf_q, res_perf_d;
  logic [WORD_W-1:0]   res_v0_q, res_v0_d;
  logic [WORD_W-1:0]   res_v1_q, res_v1_d;

  logic                out_perf_q;
  logic [WORD_W-1:0]   out_v0_q, out_v1_q;

  logic                accept;
  logic                out_load;
  logic [SIZE_W-1:0]   size_eff;
  logic [WORD_W-1:0]   mod_dividend;
  logic                mod_start;
  logic                mod_done;
  logic [SIZE_W-1:0]   mod_rem;

  logic                mem_rd, mem_wr;
  logic [WORD_W-1:0]   mem_addr_full;
  logic [WORD_W-1:0]   mem_wdata;
  logic [WORD_W-1:0]   mem_rdata;

  logic                cfg_wr;

  assign accept   = in_i.valid & in_i.ready;
  assign in_i.ready = (state_q == S_IDLE);
  assign out_load = (state_q == S_DONE) && (!out_valid_q || out_o.ready);

  // Sizes above the store are clamped to the store.
  assign size_eff = (32'(shared_bytes_q) > 32'(STORE_BYTES)) ? SIZE_W'(STORE_BYTES)
                                                             : shared_bytes_q;

  assign mod_dividend = (in_i.action == ACT_SWAP) ? in_i.lane_address
                      : in_i.lane_address + 32'(in_i.imm_offset);

  smlau_mod u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (mod_dividend),
    .divisor_i  (size_eff),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  smlau_mem #(
    .STORE_BYTES (STORE_BYTES)
  ) u_mem (
    .clk_i   (clk_i),
    .rd_en_i (mem_rd),
    .wr_en_i (mem_wr),
    .addr_i  (mem_addr_full[ADDR_W-1:0]),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    state_d       = state_q;
    addr_d        = addr_q;
    res_perf_d    = res_perf_q;
    res_v0_d      = res_v0_q;
    res_v1_d      = res_v1_q;
    mod_start     = 1'b0;
    mem_rd        = 1'b0;
    mem_wr        = 1'b0;
    mem_addr_full = '0;
    mem_wdata     = data_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_perf_d = 1'b0;
          res_v0_d   = '0;
          res_v1_d   = '0;
          if (in_i.action == ACT_PAIR) begin
            state_d = S_P0;
          end else if (is_single_word(in_i.action) && (size_eff != '0)) begin
            mod_start = 1'b1;
            state_d   = S_MOD;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_P0: begin
        if (word_fits(addr_a_q, size_q) && word_fits(addr_b_q, size_q)) begin
          mem_rd        = 1'b1;
          mem_addr_full = addr_a_q;
          state_d       = S_P1;
        end else begin
          state_d = S_DONE;
        end
      end
      S_P1: begin
        mem_rd        = 1'b1;
        mem_addr_full = addr_b_q;
        res_v0_d      = mem_rdata;
        state_d       = S_P2;
      end
      S_P2: begin
        res_v1_d   = mem_rdata;
        res_perf_d = 1'b1;
        state_d    = S_DONE;
      end
      S_MOD: begin
        if (mod_done) begin
          if (word_fits(32'(mod_rem), size_q)) begin
            mem_rd        = 1'b1;
            mem_addr_full = 32'(mod_rem);
            addr_d        = mod_rem;
            state_d       = S_EXEC;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_EXEC: begin
        mem_addr_full = 32'(addr_q);
        res_perf_d    = 1'b1;
        res_v0_d      = mem_rdata;
        case (act_q)
          ACT_WRITE: begin
            mem_wr   = 1'b1;
            res_v0_d = '0;
          end
          ACT_READ: begin
            mem_wr = 1'b0;
          end
          ACT_ADD: begin
            mem_wr    = 1'b1;
            mem_wdata = mem_rdata + data_q;
          end
          ACT_MIN: begin
            mem_wr    = 1'b1;
            mem_wdata = ($signed(data_q) < $signed(mem_rdata)) ? data_q : mem_rdata;
          end
          ACT_MAX: begin
            mem_wr    = 1'b1;
            mem_wdata = ($signed(data_q) > $signed(mem_rdata)) ? data_q : mem_rdata;
          end
          ACT_SWAP: begin
            mem_wr = 1'b1;
          end
          default: begin
            mem_wr = 1'b0;
          end
        endcase
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      out_valid_q    <= 1'b0;
      shared_bytes_q <= SHARED_BYTES_RST;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_wr && (paddr[2] == REG_SHARED_BYTES)) begin
        shared_bytes_q <= pwdata[SIZE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q    <= in_i.action;
      data_q   <= in_i.write_data;
      size_q   <= size_eff;
      addr_a_q <= in_i.lane_address + {14'b0, in_i.imm_offset, 2'b00};
      addr_b_q <= in_i.lane_address + {22'b0, in_i.second_offset, 2'b00};
    end
    addr_q     <= addr_d;
    res_perf_q <= res_perf_d;
    res_v0_q   <= res_v0_d;
    res_v1_q   <= res_v1_d;
    if (out_load) begin
      out_perf_q <= res_perf_q;
      out_v0_q   <= res_v0_q;
      out_v1_q   <= res_v1_q;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.performed    = out_perf_q;
  assign out_o.first_value  = out_v0_q;
  assign out_o.second_value = out_v1_q;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_SHARED_BYTES) ? PDATA_W'(shared_bytes_q) : '0;

endmodule

`default_nettype wire
